FILE: hw/rtl/ppf_pkg.sv
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared constants, types and the Paeth predictor function for the Paeth
// row filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ppf_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int IMG_WIDTH_W   = 13;
  localparam int IMG_HEIGHT_W  = 16;
  localparam int PIXEL_W       = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [7:0] PAETH_TYPE = 8'd4;

  localparam logic [1:0] SLOT_TYPE  = 2'd0;
  localparam logic [1:0] SLOT_RED   = 2'd1;
  localparam logic [1:0] SLOT_GREEN = 2'd2;
  localparam logic [1:0] SLOT_BLUE  = 2'd3;

  typedef logic [2:0][7:0] rgb_bytes_t;

  typedef struct packed {
    rgb_bytes_t filt;
    logic       has_type;
    logic       image_end;
  } filt_word_t;

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    abs10 = v[9] ? 10'(-v) : 10'(v);
  endfunction

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    pa = abs10(signed'({2'b00, b}) - signed'({2'b00, c}));
    pb = abs10(signed'({2'b00, a}) - signed'({2'b00, c}));
    pc = abs10(signed'({2'b00, a}) + signed'({2'b00, b}) - signed'({1'b0, c, 1'b0}));
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ppf_if.sv
// ----------------------------------------------------------------------------
// ppf_if
// Valid/ready channel interfaces for pixels, filtered bytes and register
// writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppf_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface ppf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_type_byte;
  logic       last;
  logic       image_end;
  modport source (output valid, output out_byte, output is_type_byte, output last,
                  output image_end, input ready);
  modport sink (input valid, input out_byte, input is_type_byte, input last,
                input image_end, output ready);
endinterface

interface ppf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ppf_pkg::CFG_INDEX_W-1:0] index;
  logic [ppf_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ppf_ram.sv
// ----------------------------------------------------------------------------
// ppf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ppf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                    wr_data,
  input  wire logic                                rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                    rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ppf_predict.sv
// ----------------------------------------------------------------------------
// ppf_predict
// Per-channel Paeth prediction and residue for one RGB pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module ppf_predict (
  input  wire logic [ppf_pkg::PIXEL_W-1:0] cur,
  input  wire logic [ppf_pkg::PIXEL_W-1:0] left,
  input  wire logic [ppf_pkg::PIXEL_W-1:0] above,
  input  wire logic [ppf_pkg::PIXEL_W-1:0] upper_left,
  input  wire logic                        col_zero,
  input  wire logic                        row_zero,
  output ppf_pkg::rgb_bytes_t              filt
);
  import ppf_pkg::*;

  logic [PIXEL_W-1:0] a_pix;
  logic [PIXEL_W-1:0] b_pix;
  logic [PIXEL_W-1:0] c_pix;

  assign a_pix = col_zero ? '0 : left;
  assign b_pix = row_zero ? '0 : above;
  assign c_pix = (col_zero || row_zero) ? '0 : upper_left;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      filt[ch] = cur[PIXEL_W-1-8*ch -: 8]
               - paeth(a_pix[PIXEL_W-1-8*ch -: 8], b_pix[PIXEL_W-1-8*ch -: 8],
                       c_pix[PIXEL_W-1-8*ch -: 8]);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ppf_serializer.sv
// ----------------------------------------------------------------------------
// ppf_serializer
// Output register that sends one pixel's type byte and filtered bytes one
// word per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ppf_serializer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire ppf_pkg::filt_word_t word_in,
  output logic                    can_load,
  ppf_byte_if.source              byte_out
);
  import ppf_pkg::*;

  logic       busy;
  logic       busy_next;
  logic [1:0] slot;
  logic [1:0] slot_next;
  filt_word_t word;
  logic       fire;
  logic       done;

  assign fire     = busy && byte_out.ready;
  assign done     = fire && (slot == SLOT_BLUE);
  assign can_load = !busy || done;

  always_comb begin
    busy_next = busy;
    slot_next = slot;
    if (load) begin
      busy_next = 1'b1;
      slot_next = word_in.has_type ? SLOT_TYPE : SLOT_RED;
    end else if (done) begin
      busy_next = 1'b0;
    end else if (fire) begin
      slot_next = slot + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= SLOT_TYPE;
    end else begin
      busy <= busy_next;
      slot <= slot_next;
    end
    if (load) begin
      word <= word_in;
    end
  end

  always_comb begin
    case (slot)
      SLOT_TYPE:  byte_out.out_byte = PAETH_TYPE;
      SLOT_RED:   byte_out.out_byte = word.filt[0];
      SLOT_GREEN: byte_out.out_byte = word.filt[1];
      default:    byte_out.out_byte = word.filt[2];
    endcase
  end

  assign byte_out.valid        = busy;
  assign byte_out.is_type_byte = (slot == SLOT_TYPE);
  assign byte_out.last         = (slot == SLOT_BLUE);
  assign byte_out.image_end    = (slot == SLOT_BLUE) && word.image_end;

endmodule

`default_nettype wire

FILE: hw/rtl/png_paeth_row_filter.sv
// ----------------------------------------------------------------------------
// png_paeth_row_filter
// Paeth (type 4) filter for 8-bit RGB pixels in raster order, with a row store.
// ----------------------------------------------------------------------------
// Each accepted pixel produces three filtered bytes (red, green, blue), preceded
// by the filter-type byte 4 at the first pixel of every row, one word per cycle
// on the byte channel while the receiver is ready. An accepted pixel is first
// registered in the s1 stage, where the row-store read returns and the
// prediction is formed; the word then moves into the serializer register once
// that can take it, and the serializer offers the first byte. The previous row
// lives in a MAX_WIDTH-entry RAM that needs no clearing after reset. A write
// to either register restarts the image at column 0, row 0.
`default_nettype none

module png_paeth_row_filter #(
  parameter int MAX_WIDTH = ppf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ppf_pixel_if.sink  pixel_in,
  ppf_byte_if.source byte_out,
  ppf_cfg_if.sink    cfg
);
  import ppf_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;
  logic [COL_W-1:0]        last_col;
  logic [IMG_HEIGHT_W-1:0] last_row;

  logic [COL_W-1:0]        column_count;
  logic [IMG_HEIGHT_W-1:0] row_count;
  logic [PIXEL_W-1:0]      left_pixel;
  logic [PIXEL_W-1:0]      upper_left_pixel;

  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_cur;
  logic [COL_W-1:0]   s1_col;
  logic               s1_col_zero;
  logic               s1_row_zero;
  logic               s1_eoi;
  logic               s1_fwd;
  logic [PIXEL_W-1:0] s1_fwd_data;

  logic               cfg_write;
  logic               accept;
  logic               s1_move;
  logic               can_load;
  logic [PIXEL_W-1:0] cur_in;
  logic [PIXEL_W-1:0] ram_rd;
  logic [PIXEL_W-1:0] above_raw;
  logic [PIXEL_W-1:0] above_eff;
  rgb_bytes_t         filt;
  filt_word_t         word;

  always_comb begin
    if (image_width == '0) begin
      last_col = '0;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(image_width - IMG_WIDTH_W'(1));
    end
  end

  assign last_row = (image_height == '0) ? '0 : image_height - IMG_HEIGHT_W'(1);

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid &&
                     (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT);

  assign s1_move        = s1_valid && can_load;
  assign pixel_in.ready = !s1_valid || s1_move;
  assign accept         = pixel_in.valid && pixel_in.ready;
  assign cur_in         = {pixel_in.red, pixel_in.green, pixel_in.blue};

  assign above_raw = s1_fwd ? s1_fwd_data : ram_rd;
  assign above_eff = s1_row_zero ? '0 : above_raw;

  ppf_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (s1_move),
    .wr_addr (s1_col),
    .wr_data (s1_cur),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (ram_rd)
  );

  ppf_predict u_predict (
    .cur        (s1_cur),
    .left       (left_pixel),
    .above      (above_raw),
    .upper_left (upper_left_pixel),
    .col_zero   (s1_col_zero),
    .row_zero   (s1_row_zero),
    .filt       (filt)
  );

  assign word.filt      = filt;
  assign word.has_type  = s1_col_zero;
  assign word.image_end = s1_eoi;

  ppf_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_move),
    .word_in  (word),
    .can_load (can_load),
    .byte_out (byte_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= IMG_WIDTH_W'(1);
      image_height     <= IMG_HEIGHT_W'(1);
      column_count     <= '0;
      row_count        <= '0;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      s1_valid         <= 1'b0;
    end else if (cfg_write) begin
      if (cfg.index == REG_IMAGE_WIDTH) begin
        image_width <= cfg.data[IMG_WIDTH_W-1:0];
      end else begin
        image_height <= cfg.data[IMG_HEIGHT_W-1:0];
      end
      column_count     <= '0;
      row_count        <= '0;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (column_count == last_col) begin
          column_count <= '0;
          row_count    <= (row_count == last_row) ? '0 : row_count + IMG_HEIGHT_W'(1);
        end else begin
          column_count <= column_count + COL_W'(1);
        end
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        left_pixel       <= s1_cur;
        upper_left_pixel <= above_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur      <= cur_in;
      s1_col      <= column_count;
      s1_col_zero <= (column_count == '0);
      s1_row_zero <= (row_count == '0);
      s1_eoi      <= (column_count == last_col) && (row_count == last_row);
      s1_fwd      <= s1_move && (s1_col == column_count);
      s1_fwd_data <= s1_cur;
    end
  end

endmodule

`default_nettype wire

FILE: bench/png_paeth_row_filter_checker.sv
// ----------------------------------------------------------------------------
// png_paeth_row_filter_checker
// Watches the pixel, byte and register channels of the Paeth row filter. It
// keeps its own copy of the geometry, the counters and the previous row, works
// out the filtered words that each accepted pixel must produce, and compares
// every accepted word with the oldest one still owed.
// ----------------------------------------------------------------------------
module png_paeth_row_filter_checker (
  input  logic clk,
  input  logic rst,
  ppf_pixel_if pix,
  ppf_byte_if  bytes,
  ppf_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       type_flag;
    logic       last_flag;
    logic       end_flag;
  } filt_word_t;

  filt_word_t                 owed_words[$];
  ppf_pkg::rgb_bytes_t        prev_row[ppf_pkg::MAX_WIDTH_DEF];
  ppf_pkg::rgb_bytes_t        left_px;
  ppf_pkg::rgb_bytes_t        upleft_px;
  int unsigned                col;
  int unsigned                row;
  logic [ppf_pkg::IMG_WIDTH_W-1:0]  width_reg;
  logic [ppf_pkg::IMG_HEIGHT_W-1:0] height_reg;
  int                         mismatches = 0;

  function automatic logic [7:0] paeth_guess(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
    int est;
    int da;
    int db;
    int dc;
    est = int'(a) + int'(b) - int'(c);
    da = est - int'(a);
    db = est - int'(b);
    dc = est - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  task automatic restart_image();
    col = 0;
    row = 0;
    left_px = '0;
    upleft_px = '0;
  endtask

  task automatic owe_word(input filt_word_t fw);
    owed_words.insert(owed_words.size(), fw);
  endtask

  task automatic apply_reg_write(input logic [ppf_pkg::CFG_INDEX_W-1:0] index,
                                 input logic [ppf_pkg::CFG_DATA_W-1:0] data);
    case (index)
      ppf_pkg::REG_IMAGE_WIDTH: begin
        width_reg = data[ppf_pkg::IMG_WIDTH_W-1:0];
        restart_image();
      end
      ppf_pkg::REG_IMAGE_HEIGHT: begin
        height_reg = data[ppf_pkg::IMG_HEIGHT_W-1:0];
        restart_image();
      end
      default: ;
    endcase
  endtask

  task automatic predict_pixel(input ppf_pkg::rgb_bytes_t cur);
    int unsigned         w;
    int unsigned         h;
    ppf_pkg::rgb_bytes_t above;
    ppf_pkg::rgb_bytes_t upper;
    filt_word_t          fw;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > ppf_pkg::MAX_WIDTH_DEF) w = ppf_pkg::MAX_WIDTH_DEF;
    h = (height_reg == 0) ? 1 : height_reg;
    above = (row > 0) ? prev_row[col] : '0;
    upper = (col > 0 && row > 0) ? upleft_px : '0;
    if (col == 0) begin
      fw.value = ppf_pkg::PAETH_TYPE;
      fw.type_flag = 1'b1;
      fw.last_flag = 1'b0;
      fw.end_flag = 1'b0;
      owe_word(fw);
    end
    for (int ch = 2; ch >= 0; ch--) begin
      fw.value = cur[ch] - paeth_guess((col > 0) ? left_px[ch] : 8'd0, above[ch], upper[ch]);
      fw.type_flag = 1'b0;
      fw.last_flag = (ch == 0);
      fw.end_flag = (ch == 0) && (col == w - 1) && (row == h - 1);
      owe_word(fw);
    end
    upleft_px = above;
    left_px = cur;
    prev_row[col] = cur;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endtask

  task automatic check_word();
    filt_word_t got;
    filt_word_t want;
    got = {bytes.out_byte, bytes.is_type_byte, bytes.last, bytes.image_end};
    if (owed_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected word: byte %02h type %0b last %0b end %0b", $time,
                 got.value, got.type_flag, got.last_flag, got.end_flag);
      end
    end else begin
      want = owed_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: word mismatch: expected byte %02h type %0b last %0b end %0b, %s",
                   $time, want.value, want.type_flag, want.last_flag, want.end_flag,
                   $sformatf("got byte %02h type %0b last %0b end %0b", got.value,
                             got.type_flag, got.last_flag, got.end_flag));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      owed_words.delete();
      restart_image();
      width_reg = 1;
      height_reg = 1;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        apply_reg_write(cfg.index, cfg.data);
      end
      if (bytes.valid === 1'b1 && bytes.ready === 1'b1) begin
        check_word();
      end
      if (pix.valid === 1'b1 && pix.ready === 1'b1) begin
        predict_pixel({pix.red, pix.green, pix.blue});
      end
    end
    pending <= owed_words.size();
    fail_count <= mismatches;
  end

endmodule

FILE: bench/png_paeth_row_filter_tb.sv
// ----------------------------------------------------------------------------
// png_paeth_row_filter_tb
// Drives pixels and register writes into the Paeth row filter: a short set of
// hand-picked images and geometries first, then random images of random small
// sizes under four patterns of sender gaps and receiver stalls. A separate
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module png_paeth_row_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;

  localparam logic [23:0] TIE_IMAGE[12] = '{
    24'h000000, 24'hFFFFFF, 24'h0A141E,
    24'h0AFF00, 24'hFF0080, 24'h808080,
    24'h0000FF, 24'h7F7F7F, 24'h01FE02,
    24'hFFFFFF, 24'h000000, 24'hFF00FF
  };

  logic                clk = 1'b0;
  logic                rst;
  int                  pixel_gap_pct;
  int                  byte_stall_pct;
  int                  quiet_cycles = 0;
  int                  fail_count;
  int                  pending;
  ppf_pkg::rgb_bytes_t last_px;
  int                  gap_modes[4] = '{0, 72, 0, 32};
  int                  stall_modes[4] = '{0, 0, 72, 32};

  ppf_pixel_if pixels();
  ppf_byte_if  filtered();
  ppf_cfg_if   regs();

  png_paeth_row_filter dut (
    .clk      (clk),
    .rst      (rst),
    .pixel_in (pixels),
    .byte_out (filtered),
    .cfg      (regs)
  );

  png_paeth_row_filter_checker filter_check (
    .clk        (clk),
    .rst        (rst),
    .pix        (pixels),
    .bytes      (filtered),
    .cfg        (regs),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    filtered.ready <= ($urandom_range(0, 99) >= byte_stall_pct);
  end

  always @(posedge clk) begin
    if ((pixels.valid === 1'b1 && pixels.ready === 1'b1) ||
        (filtered.valid === 1'b1 && filtered.ready === 1'b1) ||
        (regs.valid === 1'b1 && regs.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic ppf_pkg::rgb_bytes_t make_pixel(input ppf_pkg::rgb_bytes_t near);
    ppf_pkg::rgb_bytes_t px;
    for (int ch = 0; ch < 3; ch++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: px[ch] = 8'($urandom);
        4: px[ch] = 8'h00;
        5: px[ch] = 8'hFF;
        default: px[ch] = near[ch] + 8'($urandom_range(0, 4)) - 8'd2;
      endcase
    end
    return px;
  endfunction

  task automatic send_pixel(input ppf_pkg::rgb_bytes_t px);
    if ($urandom_range(0, 99) < pixel_gap_pct) begin
      pixels.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pixel_gap_pct);
    end
    pixels.valid <= 1'b1;
    pixels.red <= px[2];
    pixels.green <= px[1];
    pixels.blue <= px[0];
    do @(posedge clk); while (pixels.ready !== 1'b1);
    last_px = px;
  endtask

  task automatic write_reg(input logic [ppf_pkg::CFG_INDEX_W-1:0] index,
                           input logic [ppf_pkg::CFG_DATA_W-1:0] data);
    regs.valid <= 1'b1;
    regs.index <= index;
    regs.data <= data;
    do @(posedge clk); while (regs.ready !== 1'b1);
  endtask

  task automatic drain();
    pixels.valid <= 1'b0;
    regs.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int sent;
    int w;
    int h;
    int area;
    int n;
    sent = 0;
    while (sent < count) begin
      drain();
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      h = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(8'($urandom_range(2, 255)), 16'($urandom));
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(ppf_pkg::REG_IMAGE_WIDTH, {3'($urandom), 13'(w)});
        write_reg(ppf_pkg::REG_IMAGE_HEIGHT, 16'(h));
      end else begin
        write_reg(ppf_pkg::REG_IMAGE_HEIGHT, 16'(h));
        write_reg(ppf_pkg::REG_IMAGE_WIDTH, {3'($urandom), 13'(w)});
      end
      regs.valid <= 1'b0;
      area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      n = area + $urandom_range(0, area);
      if (n > count - sent) n = count - sent;
      repeat (n) send_pixel(make_pixel(last_px));
      sent += n;
    end
  endtask

  initial begin
    rst = 1'b1;
    pixel_gap_pct = 0;
    byte_stall_pct = 0;
    last_px = '0;
    pixels.valid <= 1'b0;
    pixels.red <= 8'h00;
    pixels.green <= 8'h00;
    pixels.blue <= 8'h00;
    regs.valid <= 1'b0;
    regs.index <= '0;
    regs.data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // With the reset geometry every pixel is a complete one-pixel image.
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    drain();

    write_reg(ppf_pkg::REG_IMAGE_WIDTH, 16'd3);
    write_reg(ppf_pkg::REG_IMAGE_HEIGHT, 16'd3);
    regs.valid <= 1'b0;
    foreach (TIE_IMAGE[i]) send_pixel(TIE_IMAGE[i]);
    drain();

    write_reg(ppf_pkg::REG_IMAGE_WIDTH, 16'd0);
    write_reg(ppf_pkg::REG_IMAGE_HEIGHT, 16'd0);
    regs.valid <= 1'b0;
    send_pixel(24'h80FF01);
    send_pixel(24'h7F0080);
    drain();

    // All ones: the width saturates to the row store size.
    write_reg(ppf_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(ppf_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
    regs.valid <= 1'b0;
    send_pixel(24'h123456);
    send_pixel(24'hFEDCBA);
    send_pixel(24'h00FF00);
    drain();

    // Writes to unknown registers must leave the image running.
    write_reg(8'd2, 16'($urandom));
    write_reg(8'hFF, 16'hFFFF);
    regs.valid <= 1'b0;
    send_pixel(24'hFF00FF);
    send_pixel(24'h010203);
    drain();

    for (int m = 0; m < 4; m++) begin
      pixel_gap_pct = gap_modes[m];
      byte_stall_pct = stall_modes[m];
      run_random(125);
    end
    drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
